@@ rtl/csb_pkg.sv @@
package csb_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 56;
    localparam int COORD_W     = 12;
    localparam int OFF_W       = 5;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 14;
    localparam int INV_IDX_W   = 12;
    localparam int INV_SIZE    = 4096;
    localparam int FWD_SIZE    = 256;
    localparam int LIN_W_MAX   = 24;
    localparam int RADIUS_SQ   = 120;
    localparam int QUEUE_DEPTH = 4;
    localparam int BIG_W       = 352;
    localparam int NUM_CH      = 3;

    typedef logic [BIG_W-1:0] t_big;
    typedef logic [LIN_W_MAX-1:0] t_lin;
    typedef t_lin [FWD_SIZE-1:0] t_fwd_tab;
    typedef logic [INV_SIZE-1:0][CH_W-1:0] t_inv_tab;

    typedef struct packed {
        logic             in_circle;
        logic             smear;
        logic [PIX_W-1:0] pixel_y;
        logic [PIX_W-1:0] pixel_x;
    } t_pix_info;

    function automatic t_big big_pow(t_big b, int unsigned e);
        t_big r;
        r = t_big'(1);
        for (int unsigned i = 0; i < e; i++) begin
            r = r * b;
        end
        return r;
    endfunction

    // sRGB decode, exact integer form of the standard curve
    function automatic t_lin fwd_code(int unsigned c, int unsigned lbits);
        logic [63:0] m;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        t_big        pk;
        t_big        rhs;
        t_big        lhs;
        m = (64'd1 << lbits) - 64'd1;
        if (c <= 10) begin
            return t_lin'((64'd200 * m * 64'(c) + 64'd329460) / 64'd658920);
        end
        pk  = big_pow(t_big'(269025), 12);
        rhs = big_pow(t_big'(64'd2 * m), 5) * big_pow(t_big'(1000 * c + 14025), 12);
        lo  = 64'd0;
        hi  = m;
        for (int i = 0; i <= LIN_W_MAX; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                lhs = big_pow(t_big'(64'd2 * mid - 64'd1), 5) * pk;
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return t_lin'(lo);
    endfunction

    function automatic t_fwd_tab build_fwd(int unsigned lbits);
        t_fwd_tab t;
        for (int unsigned c = 0; c < FWD_SIZE; c++) begin
            t[c] = fwd_code(c, lbits);
        end
        return t;
    endfunction

    function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // nearest sRGB code per 12-bit linear bucket, lower code on a tie
    function automatic t_inv_tab build_inv(int unsigned lbits);
        t_fwd_tab    f;
        t_inv_tab    t;
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] d0;
        logic [63:0] d1;
        int unsigned c;
        int unsigned j;
        logic        moving;
        f = build_fwd(lbits);
        m = (64'd1 << lbits) - 64'd1;
        c = 0;
        for (int unsigned jh = 0; jh < 64; jh++) begin
            for (int unsigned jl = 0; jl < 64; jl++) begin
                j      = jh * 64 + jl;
                b      = 64'(j) * m;
                moving = 1'b1;
                while (moving && c < FWD_SIZE - 1) begin
                    d0 = abs_diff(64'(f[c]) * 64'd4095, b);
                    d1 = abs_diff(64'(f[c + 1]) * 64'd4095, b);
                    if (d1 < d0) begin
                        c = c + 1;
                    end else begin
                        moving = 1'b0;
                    end
                end
                t[j] = CH_W'(c);
            end
        end
        return t;
    endfunction

endpackage

@@ rtl/csb_ram.sv @@
module csb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/csb_queue.sv @@
module csb_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

@@ rtl/csb_front.sv @@
module csb_front #(
    parameter int BRUSH_SIZE  = 32,
    parameter int LINEAR_BITS = 16
) (
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [csb_pkg::IN_DATA_W-1:0]         i_s_axis_tdata,
    input  logic [0:0]                            i_s_axis_tuser,
    input  logic                                  i_q_ready,
    input  logic                                  i_busy,
    output logic                                  o_push,
    output csb_pkg::t_pix_info                    o_info,
    output logic [$clog2(BRUSH_SIZE*BRUSH_SIZE)-1:0] o_idx,
    output logic [csb_pkg::NUM_CH*LINEAR_BITS-1:0] o_lin
);

    localparam int HALF = BRUSH_SIZE / 2;
    localparam int AW   = $clog2(BRUSH_SIZE * BRUSH_SIZE);
    localparam csb_pkg::t_fwd_tab FWD = csb_pkg::build_fwd(LINEAR_BITS);

    logic [csb_pkg::COORD_W-1:0] cx;
    logic [csb_pkg::COORD_W-1:0] cy;
    logic [csb_pkg::OFF_W-1:0]   ox;
    logic [csb_pkg::OFF_W-1:0]   oy;
    logic [csb_pkg::CH_W-1:0]    ch [csb_pkg::NUM_CH];
    logic signed [12:0]          dx;
    logic signed [12:0]          dy;
    logic signed [12:0]          dsq;
    logic                        in_box;

    assign cx    = i_s_axis_tdata[11:0];
    assign cy    = i_s_axis_tdata[23:12];
    assign ox    = i_s_axis_tdata[28:24];
    assign oy    = i_s_axis_tdata[33:29];
    assign ch[0] = i_s_axis_tdata[41:34];
    assign ch[1] = i_s_axis_tdata[49:42];
    assign ch[2] = i_s_axis_tdata[57:50];

    assign dx  = $signed({8'b0, ox}) - $signed(13'(HALF));
    assign dy  = $signed({8'b0, oy}) - $signed(13'(HALF));
    assign dsq = dx * dx + dy * dy;

    assign in_box = ({2'b0, ox} < 7'(BRUSH_SIZE)) && ({2'b0, oy} < 7'(BRUSH_SIZE));

    always_comb begin
        o_info.in_circle = in_box && (dsq <= $signed(13'(csb_pkg::RADIUS_SQ)));
        o_info.smear     = i_s_axis_tuser[0];
        o_info.pixel_x   = csb_pkg::PIX_W'({2'b0, cx}) + csb_pkg::PIX_W'({9'b0, ox})
                           - csb_pkg::PIX_W'(HALF);
        o_info.pixel_y   = csb_pkg::PIX_W'({2'b0, cy}) + csb_pkg::PIX_W'({9'b0, oy})
                           - csb_pkg::PIX_W'(HALF);
    end

    assign o_idx = AW'(32'(oy) * 32'(BRUSH_SIZE) + 32'(ox));

    for (genvar k = 0; k < csb_pkg::NUM_CH; k++) begin : g_lin
        assign o_lin[k*LINEAR_BITS +: LINEAR_BITS] = FWD[ch[k]][LINEAR_BITS-1:0];
    end

    assign o_s_axis_tready = i_q_ready && !i_busy;
    assign o_push          = i_s_axis_tvalid && o_s_axis_tready;

endmodule

@@ rtl/csb_back.sv @@
module csb_back #(
    parameter int BRUSH_SIZE  = 32,
    parameter int LINEAR_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [$bits(csb_pkg::t_pix_info) + $clog2(BRUSH_SIZE*BRUSH_SIZE)
                  + csb_pkg::NUM_CH*LINEAR_BITS - 1:0] i_q_data,
    output logic                                 o_pop,
    output logic                                 o_busy,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [csb_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic [0:0]                           o_m_axis_tuser
);

    localparam int DEPTH  = BRUSH_SIZE * BRUSH_SIZE;
    localparam int AW     = $clog2(DEPTH);
    localparam int INFO_W = $bits(csb_pkg::t_pix_info);
    localparam int LW     = csb_pkg::NUM_CH * LINEAR_BITS;
    localparam csb_pkg::t_inv_tab INV = csb_pkg::build_inv(LINEAR_BITS);

    csb_pkg::t_pix_info q_info;
    logic [AW-1:0]      q_idx;
    logic [LW-1:0]      q_lin;

    logic               adv;
    logic               wr_item;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LW-1:0]      ram_wdata;
    logic [LW-1:0]      ram_rdata;
    logic [LW-1:0]      stored;
    logic [LW-1:0]      merged;

    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic               n_clr_busy;
    logic [AW-1:0]      n_clr_addr;

    logic               r_b1_valid;
    csb_pkg::t_pix_info r_b1_info;
    logic [AW-1:0]      r_b1_idx;
    logic [LW-1:0]      r_b1_lin;

    logic               r_b2_valid;
    csb_pkg::t_pix_info r_b2_info;
    logic [LW-1:0]      r_b2_lin;

    logic               r_lw_valid;
    logic [AW-1:0]      r_lw_addr;
    logic [LW-1:0]      r_lw_data;

    logic               r_out_valid;
    logic [csb_pkg::OUT_DATA_W-1:0] r_out_data;
    logic               r_out_user;
    logic [csb_pkg::CH_W-1:0] color [csb_pkg::NUM_CH];

    assign q_info = i_q_data[INFO_W-1:0];
    assign q_idx  = i_q_data[INFO_W +: AW];
    assign q_lin  = i_q_data[INFO_W + AW +: LW];

    assign adv   = !r_out_valid || i_m_axis_tready;
    assign o_pop = adv && i_q_valid && !r_clr_busy;

    // newest write wins over the ram copy
    assign stored  = (r_lw_valid && (r_lw_addr == r_b1_idx)) ? r_lw_data : ram_rdata;
    assign wr_item = adv && r_b1_valid && r_b1_info.in_circle;

    for (genvar k = 0; k < csb_pkg::NUM_CH; k++) begin : g_ch
        logic [LINEAR_BITS:0] sum;
        assign sum = {1'b0, stored[k*LINEAR_BITS +: LINEAR_BITS]}
                   + {1'b0, r_b1_lin[k*LINEAR_BITS +: LINEAR_BITS]};
        assign merged[k*LINEAR_BITS +: LINEAR_BITS] =
            r_b1_info.smear ? sum[LINEAR_BITS:1] : r_b1_lin[k*LINEAR_BITS +: LINEAR_BITS];
        assign color[k] = INV[r_b2_lin[k*LINEAR_BITS + LINEAR_BITS - 1 -: csb_pkg::INV_IDX_W]];
    end

    assign ram_we    = r_clr_busy || wr_item;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_b1_idx;
    assign ram_wdata = r_clr_busy ? '0 : merged;

    csb_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop),
        .i_raddr (q_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lw_valid  <= 1'b0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            if (adv) begin
                r_b1_valid  <= o_pop;
                r_b2_valid  <= r_b1_valid;
                r_out_valid <= r_b2_valid;
            end
            if (wr_item) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_info <= q_info;
            r_b1_idx  <= q_idx;
            r_b1_lin  <= q_lin;
        end
        if (wr_item) begin
            r_lw_addr <= r_b1_idx;
            r_lw_data <= merged;
        end
        if (adv) begin
            r_b2_info  <= r_b1_info;
            r_b2_lin   <= merged;
            r_out_user <= r_b2_info.in_circle;
            if (r_b2_info.in_circle) begin
                r_out_data <= {4'b0, color[2], color[1], color[0],
                               r_b2_info.pixel_y, r_b2_info.pixel_x};
            end else begin
                r_out_data <= {4'b0, 24'b0, r_b2_info.pixel_y, r_b2_info.pixel_x};
            end
        end
    end

    assign o_busy          = r_clr_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

@@ rtl/circular_smudge_brush.sv @@
// channel    dir  handshake                    tdata / tuser
// s_axis     in   i_s_axis_tvalid/o_..._tready pixel under stamp, smear flag
// m_axis     out  o_m_axis_tvalid/i_..._tready new pixel, write flag
//
// One word per cycle sustained while m_axis is ready; queue, b1, b2, out registers.
// The rate is set by the single read-modify-write port pair of the stamp store.
// After reset the store is swept to zero over all BRUSH_SIZE*BRUSH_SIZE entries
// (1024 at default) with s_axis tready low.
// A four-word queue lets the input keep flowing while m_axis stalls.
module circular_smudge_brush #(
    parameter int BRUSH_SIZE  = 32,
    parameter int LINEAR_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // center_x, center_y, offset_x, offset_y, in_red, in_green, in_blue, 6'b0
    input  logic [csb_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // smear_on
    input  logic [0:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pixel_x, pixel_y, out_red, out_green, out_blue, 4'b0
    output logic [csb_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // write_pixel
    output logic [0:0]                        o_m_axis_tuser
);

    localparam int AW  = $clog2(BRUSH_SIZE * BRUSH_SIZE);
    localparam int LW  = csb_pkg::NUM_CH * LINEAR_BITS;
    localparam int QW  = $bits(csb_pkg::t_pix_info) + AW + LW;

    csb_pkg::t_pix_info f_info;
    logic [AW-1:0]      f_idx;
    logic [LW-1:0]      f_lin;
    logic               push;
    logic               q_ready;
    logic               q_valid;
    logic [QW-1:0]      q_data;
    logic               pop;
    logic               busy;

    csb_front #(
        .BRUSH_SIZE  (BRUSH_SIZE),
        .LINEAR_BITS (LINEAR_BITS)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_ready       (q_ready),
        .i_busy          (busy),
        .o_push          (push),
        .o_info          (f_info),
        .o_idx           (f_idx),
        .o_lin           (f_lin)
    );

    csb_queue #(
        .WIDTH (QW),
        .DEPTH (csb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_lin, f_idx, f_info}),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    csb_back #(
        .BRUSH_SIZE  (BRUSH_SIZE),
        .LINEAR_BITS (LINEAR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_busy          (busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

@@ rtl/csb_checker.sv @@
module csb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [csb_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]                     i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [csb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                     o_m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("m_axis word changed under stall");

    // store sweep blocks input right after reset
    a_sweep_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input taken during store sweep");

    // pixels outside the circle carry no colour
    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[51:28] == 24'b0)
        else $error("colour on unwritten pixel");

    // padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[55:52] == 4'b0)
        else $error("nonzero tdata padding");

endmodule

bind circular_smudge_brush csb_checker u_csb_checker (.*);
